// ===== hw/rtl/ptn3_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ptn3_pkg;
    localparam int TABLE_DEPTH   = 256;
    localparam int NEAREST_COUNT = 3;
    localparam int SLOT_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
    localparam int RANK_W        = $clog2(NEAREST_COUNT + 1);
    localparam int DIST_W        = 34;
    localparam int ENTRY_W       = 64;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_MOVE   = 2'd2,
        MODE_QUERY  = 2'd3
    } mode_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ID_EXISTS = 3'd1;
    localparam logic [2:0] ST_OCCUPIED  = 3'd2;
    localparam logic [2:0] ST_UNKNOWN   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] entry_id;
        logic [31:0] point;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        found;
        logic [31:0] nearest_id;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [DIST_W-1:0] dsq;
        logic [15:0]       y;
        logic [31:0]       id;
    } cand_t;

    function automatic logic closer(cand_t a, cand_t b);
        if (a.dsq != b.dsq)
            return a.dsq < b.dsq;
        if (a.y != b.y)
            return $signed(a.y) < $signed(b.y);
        return a.id < b.id;
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/ptn3_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ptn3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ptn3_rank.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ptn3_rank (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          clear,
    input  wire logic          ins,
    input  wire ptn3_pkg::cand_t cand,
    output ptn3_pkg::cand_t    best [ptn3_pkg::NEAREST_COUNT],
    output logic [ptn3_pkg::RANK_W-1:0] count
);
    import ptn3_pkg::*;

    cand_t best_reg [NEAREST_COUNT];
    logic [RANK_W-1:0] count_reg;
    logic [NEAREST_COUNT-1:0] beats;

    always_comb
    begin
        for (int k = 0; k < NEAREST_COUNT; k++)
            beats[k] = (RANK_W'(k) >= count_reg) || closer(cand, best_reg[k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (clear)
            count_reg <= '0;
        else if (ins && beats[NEAREST_COUNT-1] && count_reg != RANK_W'(NEAREST_COUNT))
            count_reg <= count_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (ins)
        begin
            for (int k = 0; k < NEAREST_COUNT; k++)
            begin
                if (beats[k])
                begin
                    if (k == 0 || !beats[k-1 < 0 ? 0 : k-1])
                        best_reg[k] <= cand;
                    else
                        best_reg[k] <= best_reg[k-1 < 0 ? 0 : k-1];
                end
            end
        end
    end

    assign best  = best_reg;
    assign count = count_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/point_table_nearest_three.sv =====
// Channel | Direction | Payload    | Handshake
// in      | input     | in_item_t  | in_valid / in_ready
// out     | output    | out_item_t | out_valid / out_ready
// An item scans all TABLE_DEPTH slots through one RAM read port;
// then S_DECIDE does any table write, and S_EMIT sends the results.
// Query results leave one per cycle, nearest first, while out_ready allows.
// Reset clears the used marks (flip-flops) and the control; RAM needs none.
// out stalls hold the current result; no new item is taken until done.
`timescale 1ns / 1ps
`default_nettype none
module point_table_nearest_three (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire ptn3_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output ptn3_pkg::out_item_t      out_data
);
    import ptn3_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_EMIT} state_t;

    state_t state_reg;
    in_item_t item_reg;
    logic [TABLE_DEPTH-1:0] used_reg;
    logic [CNT_W-1:0] addr_reg;
    logic [SLOT_W-1:0] rd_slot_reg;
    logic rd_vld_reg, cmp_vld_reg;
    logic id_hit_reg, pt_hit_reg, free_hit_reg;
    logic [SLOT_W-1:0] id_slot_reg, free_slot_reg;
    logic [RANK_W-1:0] emit_reg;
    cand_t cand_reg;
    logic rank_ins_reg;

    logic wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [ENTRY_W-1:0] wr_data, rd_data;
    logic rank_clear;
    cand_t best [NEAREST_COUNT];
    logic [RANK_W-1:0] best_count;

    ptn3_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(addr_reg[SLOT_W-1:0]), .rd_data(rd_data)
    );

    ptn3_rank u_rank (
        .clk(clk), .rst_n(rst_n), .clear(rank_clear), .ins(rank_ins_reg),
        .cand(cand_reg), .best(best), .count(best_count)
    );

    logic [31:0] rd_id, rd_pt;
    logic signed [16:0] dx, dy;
    logic [16:0] ax, ay;
    logic [31:0] sqx, sqy;
    logic [DIST_W-1:0] dist_sq;
    assign rd_id = rd_data[63:32];
    assign rd_pt = rd_data[31:0];
    assign dx = $signed({rd_pt[31], rd_pt[31:16]}) - $signed({item_reg.point[31],
                item_reg.point[31:16]});
    assign dy = $signed({rd_pt[15], rd_pt[15:0]}) - $signed({item_reg.point[15],
                item_reg.point[15:0]});
    assign ax = dx[16] ? 17'(-dx) : 17'(dx);
    assign ay = dy[16] ? 17'(-dy) : 17'(dy);
    // |d| never exceeds 65535, so 16 bits carry it
    assign sqx = ax[15:0] * ax[15:0];
    assign sqy = ay[15:0] * ay[15:0];
    assign dist_sq = DIST_W'(sqx) + DIST_W'(sqy);

    logic scan_done;
    assign scan_done = addr_reg == CNT_W'(TABLE_DEPTH) && !rd_vld_reg && !cmp_vld_reg
                       && !rank_ins_reg;
    assign rank_clear = state_reg == S_IDLE;
    assign in_ready = state_reg == S_IDLE;

    logic [2:0] st;
    always_comb
    begin
        st = ST_OK;
        wr_en = 1'b0;
        wr_addr = id_slot_reg;
        wr_data = {item_reg.entry_id, item_reg.point};
        case (mode_t'(item_reg.mode))
            MODE_ADD:
            begin
                wr_addr = free_slot_reg;
                if (id_hit_reg) st = ST_ID_EXISTS;
                else if (pt_hit_reg) st = ST_OCCUPIED;
                else if (!free_hit_reg) st = ST_FULL;
                else wr_en = 1'b1;
            end
            MODE_REMOVE:
                if (!id_hit_reg) st = ST_UNKNOWN;
            MODE_MOVE:
            begin
                if (!id_hit_reg) st = ST_UNKNOWN;
                else if (pt_hit_reg) st = ST_OCCUPIED;
                else wr_en = 1'b1;
            end
            default: st = ST_OK;
        endcase
        wr_en = wr_en && state_reg == S_DECIDE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg <= '0;
            out_valid <= 1'b0;
            rd_vld_reg <= 1'b0;
            cmp_vld_reg <= 1'b0;
            rank_ins_reg <= 1'b0;
            addr_reg <= '0;
            emit_reg <= '0;
        end
        else
        begin
            rank_ins_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        item_reg <= in_data;
                        addr_reg <= '0;
                        id_hit_reg <= 1'b0;
                        pt_hit_reg <= 1'b0;
                        free_hit_reg <= 1'b0;
                        rd_vld_reg <= 1'b0;
                        cmp_vld_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                S_SCAN:
                begin
                    rd_vld_reg <= addr_reg != CNT_W'(TABLE_DEPTH);
                    rd_slot_reg <= addr_reg[SLOT_W-1:0];
                    if (addr_reg != CNT_W'(TABLE_DEPTH))
                    begin
                        if (!used_reg[addr_reg[SLOT_W-1:0]] && !free_hit_reg)
                        begin
                            free_hit_reg <= 1'b1;
                            free_slot_reg <= addr_reg[SLOT_W-1:0];
                        end
                        addr_reg <= addr_reg + 1'b1;
                    end
                    cmp_vld_reg <= 1'b0;
                    if (rd_vld_reg && used_reg[rd_slot_reg])
                    begin
                        if (rd_id == item_reg.entry_id)
                        begin
                            id_hit_reg <= 1'b1;
                            id_slot_reg <= rd_slot_reg;
                        end
                        if (rd_pt == item_reg.point)
                            pt_hit_reg <= 1'b1;
                        cand_reg <= '{dsq: dist_sq, y: rd_pt[15:0], id: rd_id};
                        rank_ins_reg <= item_reg.mode == MODE_QUERY;
                        cmp_vld_reg <= 1'b1;
                    end
                    if (scan_done)
                        state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (item_reg.mode == MODE_ADD && wr_en)
                        used_reg[free_slot_reg] <= 1'b1;
                    if (item_reg.mode == MODE_REMOVE && id_hit_reg)
                        used_reg[id_slot_reg] <= 1'b0;
                    out_valid <= 1'b1;
                    emit_reg <= '0;
                    if (item_reg.mode == MODE_QUERY && best_count != '0)
                        out_data <= '{status: ST_OK, found: 1'b1, nearest_id: best[0].id,
                                      last: best_count == RANK_W'(1)};
                    else
                        out_data <= '{status: st, found: 1'b0, nearest_id: 32'd0,
                                      last: 1'b1};
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                    if (out_ready)
                    begin
                        if (out_data.last)
                        begin
                            out_valid <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            emit_reg <= emit_reg + 1'b1;
                            for (int k = 1; k < NEAREST_COUNT; k++)
                                if (RANK_W'(k) == emit_reg + 1'b1)
                                    out_data <= '{status: ST_OK, found: 1'b1,
                                                  nearest_id: best[k].id,
                                                  last: best_count == RANK_W'(k + 1)};
                        end
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ptn3_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ptn3_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire ptn3_pkg::out_item_t out_data
);
    import ptn3_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while results pending");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after an accepted item");
    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.nearest_id == 32'd0 && out_data.last)
        else $error("non-query result malformed");
    a_query_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.found |-> out_data.status == ST_OK)
        else $error("query result with bad status");
endmodule

bind point_table_nearest_three ptn3_checker u_ptn3_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
